>>> sv/bsle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsle_pkg
// Shared types and constants for the bounded sequence list engine: command
// codes, fixed field widths and the control bundle driven into the cell row.
// ----------------------------------------------------------------------------
package bsle_pkg;

    // Fixed item field widths
    localparam int CMD_W       = 4;
    localparam int POS_W       = 6;
    localparam int VAL_W       = 32;
    localparam int CNT_OUT_W   = 7;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;

    // Defaults for the top level parameters
    localparam int DEPTH_DEFAULT = 64;
    localparam int WIDTH_DEFAULT = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_ASSIGN     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_ERASE      = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_GET        = 4'd8;
    localparam logic [CMD_W-1:0] CMD_SORT       = 4'd9;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic shift_up;    // cells at and above op_pos move up, op_pos takes value
        logic shift_down;  // cells at and above op_pos take their upper neighbor
        logic write;       // cell at op_pos takes value
        logic sort_en;     // one odd-even transposition step
        logic phase;       // parity of the lower cell of each compared pair
        logic sign;        // compare as two's complement
    } cell_ctl_t;

endpackage

>>> sv/bsle_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsle_cell
// One list slot. Holds one element and trades it with its neighbors on
// shifts and on odd-even transposition sort steps.
// ----------------------------------------------------------------------------
module bsle_cell #(
    parameter int INDEX = 0,
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  bsle_pkg::cell_ctl_t  ctl,
    input  logic [CW-1:0]        op_pos,
    input  logic [CW-1:0]        count,
    input  logic [WIDTH-1:0]     value,
    input  logic [WIDTH-1:0]     left_val,
    input  logic [WIDTH-1:0]     right_val,
    output logic [WIDTH-1:0]     entry
);
    import bsle_pkg::*;

    localparam logic [CW-1:0] IDX      = CW'(INDEX);
    localparam logic [CW-1:0] IDX_NEXT = CW'(INDEX + 1);
    localparam logic          IDX_ODD  = 1'(INDEX % 2);

    logic [WIDTH-1:0] entry_reg;
    logic [WIDTH-1:0] entry_next;
    logic [WIDTH-1:0] flip;
    logic [WIDTH-1:0] key_mine;
    logic [WIDTH-1:0] key_left;
    logic [WIDTH-1:0] key_right;
    logic             pair_low;

    // Flip the top bit for signed order so an unsigned compare works
    assign flip      = WIDTH'(ctl.sign) << (WIDTH - 1);
    assign key_mine  = entry_reg ^ flip;
    assign key_left  = left_val ^ flip;
    assign key_right = right_val ^ flip;
    assign pair_low  = (IDX_ODD == ctl.phase);

    // Select the next element
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.write && (IDX == op_pos))
        begin
            entry_next = value;
        end
        else if (ctl.shift_up)
        begin
            if (IDX == op_pos)
                entry_next = value;
            else if (IDX > op_pos)
                entry_next = left_val;
        end
        else if (ctl.shift_down)
        begin
            if (IDX >= op_pos)
                entry_next = right_val;
        end
        else if (ctl.sort_en)
        begin
            if (pair_low)
            begin
                if ((IDX_NEXT < count) && (key_right < key_mine))
                    entry_next = right_val;
            end
            else if ((INDEX > 0) && (IDX < count) && (key_mine < key_left))
            begin
                entry_next = left_val;
            end
        end
    end

    // Hold the element
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> sv/bsle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsle_ctrl
// Command decode, bounds checks, element count, sort sequencer, the
// configuration register and the result register.
// ----------------------------------------------------------------------------
module bsle_ctrl #(
    parameter int DEPTH = 64,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // command side
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic [bsle_pkg::CMD_W-1:0]        command,
    input  logic [bsle_pkg::POS_W-1:0]        position,
    input  logic [bsle_pkg::VAL_W-1:0]        rd_data,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    // cell row
    output bsle_pkg::cell_ctl_t               ctl,
    output logic [CW-1:0]                     op_pos,
    output logic [CW-1:0]                     count,
    // result side
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic                              res_status,
    output logic [bsle_pkg::VAL_W-1:0]        res_read_value,
    output logic [bsle_pkg::CNT_OUT_W-1:0]    res_count
);
    import bsle_pkg::*;

    localparam int XW = (CW > POS_W) ? CW + 1 : POS_W + 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_SORT = 1'b1;

    logic                 state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        sort_cnt_reg, sort_cnt_next;
    logic                 sign_reg;
    logic                 res_valid_reg;
    logic                 res_status_reg;
    logic [VAL_W-1:0]     res_rd_reg;
    logic [CNT_OUT_W-1:0] res_count_reg;

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic [XW-1:0]        pos_x;
    logic [XW-1:0]        cnt_x;
    logic                 err;
    logic                 do_read;
    logic                 start_sort;
    logic                 sort_done;
    logic                 load_res;
    logic                 res_err;
    logic [VAL_W-1:0]     res_rd;

    assign cmd_ready = (state_reg == ST_RUN) && (!res_valid_reg || res_ready);
    assign accept    = cmd_valid && cmd_ready;
    assign cfg_ready = 1'b1;

    assign full  = (count_reg == FULL_COUNT);
    assign empty = (count_reg == '0);
    assign pos_x = XW'(position);
    assign cnt_x = XW'(count_reg);

    // Decode the command and check its bounds
    always_comb
    begin
        ctl            = '0;
        ctl.sign       = sign_reg;
        op_pos         = CW'(position);
        count_next     = count_reg;
        err            = 1'b0;
        do_read        = 1'b0;
        start_sort     = 1'b0;
        unique case (command)
            CMD_PUSH_BACK:
            begin
                err       = full;
                op_pos    = count_reg;
                ctl.write = accept && !full;
                if (accept && !full)
                    count_next = count_reg + 1'b1;
            end
            CMD_PUSH_FRONT:
            begin
                err          = full;
                op_pos       = '0;
                ctl.shift_up = accept && !full;
                if (accept && !full)
                    count_next = count_reg + 1'b1;
            end
            CMD_INSERT:
            begin
                err          = full || (pos_x > cnt_x);
                ctl.shift_up = accept && !err;
                if (accept && !err)
                    count_next = count_reg + 1'b1;
            end
            CMD_ASSIGN:
            begin
                err       = (pos_x >= cnt_x);
                ctl.write = accept && !err;
            end
            CMD_POP_BACK:
            begin
                err = empty;
                if (accept && !empty)
                    count_next = count_reg - 1'b1;
            end
            CMD_POP_FRONT:
            begin
                err            = empty;
                op_pos         = '0;
                ctl.shift_down = accept && !empty;
                if (accept && !empty)
                    count_next = count_reg - 1'b1;
            end
            CMD_ERASE:
            begin
                err            = (pos_x >= cnt_x);
                ctl.shift_down = accept && !err;
                if (accept && !err)
                    count_next = count_reg - 1'b1;
            end
            CMD_CLEAR:
            begin
                if (accept)
                    count_next = '0;
            end
            CMD_GET:
            begin
                err     = (pos_x >= cnt_x);
                do_read = !err;
            end
            CMD_SORT:
            begin
                start_sort = accept && (count_reg > CW'(1));
            end
            default:
            begin
                err = 1'b1;
            end
        endcase
        // Sort steps override the idle decode
        if (state_reg == ST_SORT)
        begin
            ctl            = '0;
            ctl.sign       = sign_reg;
            ctl.sort_en    = 1'b1;
            ctl.phase      = sort_cnt_reg[0];
            count_next     = count_reg;
            start_sort     = 1'b0;
        end
    end

    // Sequence the sort: one transposition step per stored element
    assign sort_done = (state_reg == ST_SORT) && (sort_cnt_reg == CW'(1));

    always_comb
    begin
        state_next    = state_reg;
        sort_cnt_next = sort_cnt_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (start_sort)
                begin
                    state_next    = ST_SORT;
                    sort_cnt_next = count_reg;
                end
            end
            ST_SORT:
            begin
                sort_cnt_next = sort_cnt_reg - 1'b1;
                if (sort_done)
                    state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Build the result
    assign load_res = (accept && !start_sort) || sort_done;
    assign res_err  = sort_done ? 1'b0 : err;
    assign res_rd   = (!sort_done && do_read) ? rd_data : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            count_reg     <= '0;
            sort_cnt_reg  <= '0;
            sign_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            sort_cnt_reg <= sort_cnt_next;
            if (cfg_valid && cfg_ready)
                sign_reg <= cfg_data;
            if (load_res)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_status_reg <= res_err;
            res_rd_reg     <= res_rd;
            res_count_reg  <= CNT_OUT_W'(count_next);
        end
    end

    assign count          = count_reg;
    assign res_valid      = res_valid_reg;
    assign res_status     = res_status_reg;
    assign res_read_value = res_rd_reg;
    assign res_count      = res_count_reg;

endmodule

>>> sv/bounded_sequence_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_sequence_list_engine
// Ordered list of up to DEPTH elements held in a row of cells, with push,
// pop, insert, erase, assign, get, clear and an ascending sort.
// ----------------------------------------------------------------------------
// Every command item returns exactly one result item holding a status, the
// value read by get (zero otherwise) and the element count after the
// command. Push, pop, insert, erase, assign, get and clear shift or load
// every cell of the row at once, so a new command item is taken each
// cycle while the result register can be emptied. Sort runs odd-even
// transposition steps through the cell row, one step per cycle, count
// steps in all, then returns its result; no item is taken meanwhile.
// compare_signed (cfg_data) picks unsigned or two's complement order and
// must be written only while the engine is idle; the engine itself does
// not enforce this. Only elements below the count may be read; a write
// beyond that range fails with status 1 and leaves the list as it was.
// ----------------------------------------------------------------------------
module bounded_sequence_list_engine #(
    parameter int DEPTH = bsle_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = bsle_pkg::WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // command items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bsle_pkg::S_TDATA_W-1:0]    s_tdata,   // position[5:0], element_value[37:6]
    input  logic [bsle_pkg::CMD_W-1:0]        s_tuser,   // command[3:0]
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bsle_pkg::M_TDATA_W-1:0]    m_tdata,   // read_value[31:0], element_count[38:32]
    output logic                              m_tuser,   // status[0]
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data   // compare_signed
);
    import bsle_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    cell_ctl_t            ctl;
    logic [CW-1:0]        op_pos;
    logic [CW-1:0]        count;
    logic [WIDTH-1:0]     value;
    logic [WIDTH-1:0]     cell_q [DEPTH];
    logic [AW-1:0]        rd_idx;
    logic [VAL_W-1:0]     rd_data;
    logic [POS_W-1:0]     position;
    logic                 res_status;
    logic [VAL_W-1:0]     res_read_value;
    logic [CNT_OUT_W-1:0] res_count;

    // Unpack the command item
    assign position = s_tdata[POS_W-1:0];
    assign value    = WIDTH'(s_tdata[POS_W +: VAL_W]);

    // Read the addressed cell for get
    assign rd_idx  = AW'(position);
    assign rd_data = VAL_W'(cell_q[rd_idx]);

    bsle_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (s_tvalid),
        .cmd_ready      (s_tready),
        .command        (s_tuser),
        .position       (position),
        .rd_data        (rd_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .ctl            (ctl),
        .op_pos         (op_pos),
        .count          (count),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .res_status     (res_status),
        .res_read_value (res_read_value),
        .res_count      (res_count)
    );

    // Chain the cells, ends tied back to themselves
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WIDTH-1:0] left_val;
        logic [WIDTH-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = cell_q[i];
        end
        else
        begin : g_inner_l
            assign left_val = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_val = cell_q[i];
        end
        else
        begin : g_inner_r
            assign right_val = cell_q[i+1];
        end

        bsle_cell #(
            .INDEX (i),
            .DEPTH (DEPTH),
            .WIDTH (WIDTH)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .op_pos    (op_pos),
            .count     (count),
            .value     (value),
            .left_val  (left_val),
            .right_val (right_val),
            .entry     (cell_q[i])
        );
    end

    // Pack the result item
    assign m_tdata = {1'b0, res_count, res_read_value};
    assign m_tuser = res_status;

endmodule

>>> verif/bounded_sequence_list_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_sequence_list_engine_tb
// Self-checking bench for the bounded sequence list engine. A short command
// table covers the error cases, both ends of the fields and the sort corner
// cases. Random command streams follow, steered toward an empty or a full
// list, under several idle and stall patterns and both sort orders. Every
// result item is checked against its table row or a behavioral list kept in the bench.
// ----------------------------------------------------------------------------
module bounded_sequence_list_engine_tb;
    import bsle_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 125;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
    localparam int CYCLE_LIMIT  = 1000000;

    // Codes outside the command set
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd10;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic                 status;
        logic [VAL_W-1:0]     read_value;
        logic [CNT_OUT_W-1:0] element_count;
    } list_result_t;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        bit               fixed;
        list_result_t     want;
    } cmd_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data = 1'b0;

    // Behavioral copy of the list
    logic [VAL_W-1:0] list_mem [DEPTH];
    int               list_len = 0;
    logic             sort_signed = 1'b0;

    list_result_t     pending_results [$];
    cmd_row_t         cmd_table [$];
    list_result_t     got_result;
    list_result_t     want_result;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_reqs      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int errors         = 0;
    int cycle_count    = 0;

    bounded_sequence_list_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Apply one command to the list copy and return its result
    function automatic list_result_t apply_list_cmd(input logic [CMD_W-1:0] cmd,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic [VAL_W-1:0] val);
        list_result_t     res;
        logic [VAL_W-1:0] t;
        int               k;
        int               j;
        bit               swap;
        res = '0;
        case (cmd)
            CMD_PUSH_BACK:
                if (list_len >= DEPTH) res.status = 1'b1;
                else
                begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            CMD_PUSH_FRONT:
                if (list_len >= DEPTH) res.status = 1'b1;
                else
                begin
                    for (k = list_len; k > 0; k--) list_mem[k] = list_mem[k-1];
                    list_mem[0] = val;
                    list_len++;
                end
            CMD_INSERT:
                if (list_len >= DEPTH || int'(pos) > list_len) res.status = 1'b1;
                else
                begin
                    for (k = list_len; k > int'(pos); k--) list_mem[k] = list_mem[k-1];
                    list_mem[pos] = val;
                    list_len++;
                end
            CMD_ASSIGN:
                if (int'(pos) >= list_len) res.status = 1'b1;
                else list_mem[pos] = val;
            CMD_POP_BACK:
                if (list_len == 0) res.status = 1'b1;
                else list_len--;
            CMD_POP_FRONT:
                if (list_len == 0) res.status = 1'b1;
                else
                begin
                    for (k = 0; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
                    list_len--;
                end
            CMD_ERASE:
                if (int'(pos) >= list_len) res.status = 1'b1;
                else
                begin
                    for (k = int'(pos); k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
                    list_len--;
                end
            CMD_CLEAR:
                list_len = 0;
            CMD_GET:
                if (int'(pos) >= list_len) res.status = 1'b1;
                else res.read_value = list_mem[pos];
            CMD_SORT:
                // Plain bubble sort gives the same order as the cell row
                for (k = 0; k + 1 < list_len; k++)
                begin
                    for (j = 0; j + 1 < list_len - k; j++)
                    begin
                        if (sort_signed)
                            swap = $signed(list_mem[j+1]) < $signed(list_mem[j]);
                        else
                            swap = list_mem[j+1] < list_mem[j];
                        if (swap)
                        begin
                            t             = list_mem[j];
                            list_mem[j]   = list_mem[j+1];
                            list_mem[j+1] = t;
                        end
                    end
                end
            default:
                res.status = 1'b1;
        endcase
        res.element_count = list_len[CNT_OUT_W-1:0];
        return res;
    endfunction

    // Steer the list length toward a target; pushes at the full mark fail
    function automatic logic [CMD_W-1:0] pick_cmd(input int target);
        int               r;
        int               grow_pct;
        logic [CMD_W-1:0] off;
        r = $urandom_range(0, 99);
        grow_pct = (list_len < target) ? 90 : (list_len > target) ? 10 : 50;
        if (r < 3)
        begin
            off = CMD_W'($urandom_range(0, 5));
            return CMD_UNUSED_LO + off;
        end
        if (r < 4) return CMD_CLEAR;
        if (r < 10) return CMD_SORT;
        if (r < 20) return CMD_GET;
        if (r < 28) return CMD_ASSIGN;
        if ($urandom_range(0, 99) < grow_pct)
        begin
            r = $urandom_range(0, 2);
            return (r == 0) ? CMD_PUSH_BACK : (r == 1) ? CMD_PUSH_FRONT : CMD_INSERT;
        end
        r = $urandom_range(0, 2);
        return (r == 0) ? CMD_POP_BACK : (r == 1) ? CMD_POP_FRONT : CMD_ERASE;
    endfunction

    // Mostly positions up to the count, some over the whole field
    function automatic logic [POS_W-1:0] pick_pos();
        if (list_len == 0 || $urandom_range(0, 4) == 0) return POS_W'($urandom_range(0, 63));
        return POS_W'($urandom_range(0, (list_len > 63) ? 63 : list_len));
    endfunction

    // Favor the sign and range boundaries so both sort orders differ
    function automatic logic [VAL_W-1:0] pick_val();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val, input bit fixed,
                           input logic st, input logic [VAL_W-1:0] rd,
                           input logic [CNT_OUT_W-1:0] cnt);
        cmd_row_t row;
        row.cmd   = cmd;
        row.pos   = pos;
        row.val   = val;
        row.fixed = fixed;
        row.want  = {st, rd, cnt};
        cmd_table.push_back(row);
    endtask

    // Offer one command item, record its result once taken
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val, input bit fixed,
                            input list_result_t want);
        list_result_t predicted;
        while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, val, pos};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predicted = apply_list_cmd(cmd, pos, val);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    // Drop valid and wait until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_compare_mode(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid   <= 1'b0;
        sort_signed = mode;
    endtask

    // Result side ready, with random stalls and requested long hold-offs
    always @(posedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each result item with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_result = {m_tuser, m_tdata[31:0], m_tdata[38:32]};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result item: status %0d read_value %h count %0d",
                         $time, got_result.status, got_result.read_value,
                         got_result.element_count);
                errors++;
            end
            else
            begin
                want_result = pending_results.pop_front();
                if (got_result.status !== want_result.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                             want_result.status, got_result.status);
                    errors++;
                end
                if (got_result.read_value !== want_result.read_value)
                begin
                    $display("%0t: read_value mismatch: expected %h, actual %h", $time,
                             want_result.read_value, got_result.read_value);
                    errors++;
                end
                if (got_result.element_count !== want_result.element_count)
                begin
                    $display("%0t: element_count mismatch: expected %0d, actual %0d", $time,
                             want_result.element_count, got_result.element_count);
                    errors++;
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int               i;
        int               p;
        int               n;
        int               target;
        int               dwell;
        logic [CMD_W-1:0] c;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] v;

        // Directed table: error cases on an empty list, field ends, sort corners
        add_row(CMD_POP_BACK,   6'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h0, 7'd0);
        add_row(CMD_POP_FRONT,  6'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h0, 7'd0);
        add_row(CMD_GET,        6'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h0, 7'd0);
        add_row(CMD_ERASE,      6'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h0, 7'd0);
        add_row(CMD_ASSIGN,     6'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, 7'd0);
        add_row(CMD_INSERT,     6'd1,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, 7'd0);
        add_row(CMD_INSERT,     6'd0,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 7'd1);
        add_row(CMD_PUSH_BACK,  6'd63, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd2);
        add_row(CMD_PUSH_FRONT, 6'd0,  32'h8000_0000, 1'b1, 1'b0, 32'h0, 7'd3);
        add_row(CMD_GET,        6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h8000_0000, 7'd3);
        add_row(CMD_GET,        6'd2,  32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd3);
        add_row(CMD_GET,        6'd63, 32'h0000_0000, 1'b1, 1'b1, 32'h0, 7'd3);
        add_row(CMD_ASSIGN,     6'd1,  32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 7'd0);
        add_row(CMD_INSERT,     6'd3,  32'h0000_0001, 1'b0, 1'b0, 32'h0, 7'd0);
        add_row(CMD_INSERT,     6'd5,  32'h0000_0002, 1'b1, 1'b1, 32'h0, 7'd4);
        add_row(CMD_SORT,       6'd0,  32'h0000_0000, 1'b0, 1'b0, 32'h0, 7'd0);
        add_row(CMD_GET,        6'd3,  32'h0000_0000, 1'b0, 1'b0, 32'h0, 7'd0);
        add_row(CMD_ERASE,      6'd1,  32'h0000_0000, 1'b0, 1'b0, 32'h0, 7'd0);
        add_row(CMD_POP_FRONT,  6'd0,  32'h0000_0000, 1'b0, 1'b0, 32'h0, 7'd0);
        add_row(CMD_UNUSED_HI,  6'd63, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, 7'd2);
        add_row(CMD_UNUSED_LO,  6'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h0, 7'd2);
        add_row(CMD_GET,        6'd1,  32'h0000_0000, 1'b0, 1'b0, 32'h0, 7'd0);
        add_row(CMD_CLEAR,      6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd0);
        add_row(CMD_SORT,       6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd0);
        add_row(CMD_PUSH_BACK,  6'd0,  32'h0000_0005, 1'b1, 1'b0, 32'h0, 7'd1);
        add_row(CMD_SORT,       6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd1);
        add_row(CMD_GET,        6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h5, 7'd1);

        // Hold reset, then release
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_compare_mode(1'b0);
        for (i = 0; i < cmd_table.size(); i++)
            send_cmd(cmd_table[i].cmd, cmd_table[i].pos, cmd_table[i].val,
                     cmd_table[i].fixed, cmd_table[i].want);

        // Random phases: each idle pattern under both sort orders
        target = DEPTH;
        dwell  = 0;
        for (p = 0; p < PHASES; p++)
        begin
            drain_results();
            send_gap_pct   = (p % 4 == 1) ? 52 : (p % 4 == 3) ? 21 : 0;
            recv_stall_pct = (p % 4 == 2) ? 52 : (p % 4 == 3) ? 21 : 0;
            write_compare_mode(1'(((p >> 2) ^ (p >> 1)) & 1));
            // Long receiver hold-off while the sender keeps offering
            if (p == 2) hold_reqs++;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Sender pause until the engine has answered everything
                if (p == 5 && n == PHASE_ITEMS / 2) drain_results();
                if (list_len >= target - 2 && list_len <= target + 2) dwell++;
                if (dwell > 15)
                begin
                    dwell = 0;
                    case ($urandom_range(0, 3))
                        0: target = 0;
                        1: target = DEPTH;
                        default: target = $urandom_range(0, DEPTH);
                    endcase
                end
                c   = pick_cmd(target);
                pos = pick_pos();
                v   = pick_val();
                send_cmd(c, pos, v, 1'b0, '0);
            end
        end

        // Let the last results in and watch for strays
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
